[hw/rtl/dcfp_pkg.sv]
// Shared types and constants for the delimited command frame parser.
// Holds store geometry, entry kind codes, register indexes and the
// command and status bundles between the controller and the datapath.
`default_nettype none

package dcfp_pkg;

	// Store geometry.
	localparam int DATA_DEPTH = 15;
	localparam int PASS_DEPTH = 5;
	localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int PASS_AW    = (PASS_DEPTH > 1) ? $clog2(PASS_DEPTH) : 1;
	localparam int DATA_CW    = $clog2(DATA_DEPTH + 1);
	localparam int PASS_CW    = $clog2(PASS_DEPTH + 1);
	localparam int CUR_W      = (DATA_CW > PASS_CW) ? DATA_CW : PASS_CW;

	// Field widths.
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 2;
	localparam int ENTRY_IDX_W = 4;
	localparam int CFG_IDX_W   = 2;

	// Register reset values.
	localparam logic [BYTE_W-1:0] START_RST = 8'd2;
	localparam logic [BYTE_W-1:0] STOP_RST  = 8'd3;
	localparam logic [BYTE_W-1:0] PASS_RST  = 8'd35;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_MARKER = 2'd2;

	// Kind of one result entry.
	typedef enum logic [KIND_W-1:0] {
		KIND_TYPE = 2'd0,
		KIND_DATA = 2'd1,
		KIND_PASS = 2'd2
	} entry_kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic take_byte;
		logic load_item;
	} dcfp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic stop_hit;
		logic out_free;
		logic item_last;
	} dcfp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/dcfp_rx_if.sv]
// Input channel of the frame parser: one received byte per beat.
// Depends on dcfp_pkg for the byte width.
`default_nettype none

interface dcfp_rx_if import dcfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/dcfp_entry_if.sv]
// Output channel of the frame parser: one run entry per beat.
// Depends on dcfp_pkg for the field widths.
`default_nettype none

interface dcfp_entry_if import dcfp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      entry_kind;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [BYTE_W-1:0]      entry_value;
	logic                   frame_overflow;
	logic                   last_entry;

	modport source(output valid, output entry_kind, output entry_index,
		output entry_value, output frame_overflow, output last_entry, input ready);
	modport sink(input valid, input entry_kind, input entry_index,
		input entry_value, input frame_overflow, input last_entry, output ready);
endinterface

`default_nettype wire

[hw/rtl/dcfp_ctrl.sv]
// Controller of the frame parser: takes bytes, then walks out one run.
// Depends on dcfp_pkg for the command and status bundles.
`default_nettype none

module dcfp_ctrl import dcfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire dcfp_sts_t sts,
	output dcfp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'b01,
		ST_EMIT   = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// Bytes are taken only while no run is being sent.
	assign in_ready      = (state_q == ST_ACCEPT);
	assign cmd.take_byte = in_valid && in_ready;
	assign cmd.load_item = (state_q == ST_EMIT) && sts.out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCEPT: begin
				if (cmd.take_byte && sts.stop_hit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.load_item && sts.item_last) begin
					state_d = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	// A closing stop byte always starts a run.
	a_stop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte && sts.stop_hit |=> state_q == ST_EMIT)
		else $error("closing stop byte did not start a run");

	// The run goes on until its last entry is loaded.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item && !sts.item_last |=> state_q == ST_EMIT)
		else $error("run ended before its last entry");

	// No entry is loaded while bytes are being taken.
	a_no_load_in_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte |-> !cmd.load_item)
		else $error("entry loaded while taking a byte");

endmodule

`default_nettype wire

[hw/rtl/dcfp_datapath.sv]
// Datapath of the frame parser: frame state, data and password stores,
// run cursor and the output register. Depends on dcfp_pkg.
`default_nettype none

module dcfp_datapath import dcfp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [BYTE_W-1:0]      cfg_wdata,
	input  wire logic [BYTE_W-1:0]      rx_byte,
	input  wire logic                   out_ready,
	input  wire dcfp_cmd_t              cmd,
	output dcfp_sts_t                   sts,
	output logic                        out_valid,
	output logic [KIND_W-1:0]           out_kind,
	output logic [ENTRY_IDX_W-1:0]      out_index,
	output logic [BYTE_W-1:0]           out_value,
	output logic                        out_overflow,
	output logic                        out_last
);

	// Configuration registers.
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] stop_byte_q;
	logic [BYTE_W-1:0] pass_marker_q;

	// Frame state.
	logic               in_frame_q;
	logic               type_pending_q;
	logic               pass_mode_q;
	logic               dropped_q;
	logic [BYTE_W-1:0]  frame_type_q;
	logic [DATA_CW-1:0] data_count_q;
	logic [PASS_CW-1:0] pass_count_q;

	// Stores.
	logic [BYTE_W-1:0] data_store_q [DATA_DEPTH];
	logic [BYTE_W-1:0] pass_store_q [PASS_DEPTH];

	// Run cursor.
	entry_kind_t      cur_kind_q;
	logic [CUR_W-1:0] cur_idx_q;

	// Output register.
	logic                   valid_q;
	entry_kind_t            kind_q;
	logic [ENTRY_IDX_W-1:0] index_q;
	logic [BYTE_W-1:0]      value_q;
	logic                   overflow_q;
	logic                   last_q;

	// Byte decode.
	logic is_start;
	logic is_stop;
	logic is_marker;
	logic data_full;
	logic pass_full;
	logic body_byte;
	logic data_wr;
	logic pass_wr;

	// Item selection.
	logic [CUR_W-1:0]  idx_inc;
	logic [CUR_W-1:0]  data_cnt_ext;
	logic [CUR_W-1:0]  pass_cnt_ext;
	logic [BYTE_W-1:0] item_value;
	logic              item_last;
	entry_kind_t       next_kind;
	logic [CUR_W-1:0]  next_idx;

	assign is_start  = (rx_byte == start_byte_q);
	assign is_stop   = (rx_byte == stop_byte_q);
	assign is_marker = (rx_byte == pass_marker_q);
	assign data_full = (data_count_q == DATA_CW'(DATA_DEPTH));
	assign pass_full = (pass_count_q == PASS_CW'(PASS_DEPTH));

	// A frame byte that is not stop, type or marker goes to its store if not full.
	assign body_byte = cmd.take_byte && in_frame_q && !is_stop && !type_pending_q
		&& !is_marker;
	assign data_wr = body_byte && !pass_mode_q && !data_full;
	assign pass_wr = body_byte && pass_mode_q && !pass_full;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_RST;
			stop_byte_q   <= STOP_RST;
			pass_marker_q <= PASS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_BYTE:  start_byte_q  <= cfg_wdata;
				CFG_STOP_BYTE:   stop_byte_q   <= cfg_wdata;
				CFG_PASS_MARKER: pass_marker_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Frame state update for each taken byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			type_pending_q <= 1'b0;
			pass_mode_q    <= 1'b0;
			dropped_q      <= 1'b0;
			frame_type_q   <= '0;
			data_count_q   <= '0;
			pass_count_q   <= '0;
		end else if (cmd.take_byte) begin
			if (!in_frame_q) begin
				if (is_start) begin
					in_frame_q     <= 1'b1;
					type_pending_q <= 1'b1;
					pass_mode_q    <= 1'b0;
					dropped_q      <= 1'b0;
					data_count_q   <= '0;
					pass_count_q   <= '0;
				end
			end else if (is_stop) begin
				in_frame_q     <= 1'b0;
				type_pending_q <= 1'b0;
				pass_mode_q    <= 1'b0;
			end else if (type_pending_q) begin
				frame_type_q   <= rx_byte;
				type_pending_q <= 1'b0;
			end else if (is_marker) begin
				pass_mode_q <= 1'b1;
			end else if (pass_mode_q) begin
				if (pass_full) begin
					dropped_q <= 1'b1;
				end else begin
					pass_count_q <= pass_count_q + 1'b1;
				end
			end else begin
				if (data_full) begin
					dropped_q <= 1'b1;
				end else begin
					data_count_q <= data_count_q + 1'b1;
				end
			end
		end
	end

	// Store writes at the current fill position.
	always_ff @(posedge clk) begin
		if (data_wr) begin
			data_store_q[data_count_q[DATA_AW-1:0]] <= rx_byte;
		end
		if (pass_wr) begin
			pass_store_q[pass_count_q[PASS_AW-1:0]] <= rx_byte;
		end
	end

	// Current run entry and where the cursor goes next.
	assign idx_inc      = cur_idx_q + 1'b1;
	assign data_cnt_ext = CUR_W'(data_count_q);
	assign pass_cnt_ext = CUR_W'(pass_count_q);

	always_comb begin
		item_value = frame_type_q;
		item_last  = 1'b1;
		next_kind  = KIND_PASS;
		next_idx   = '0;
		case (cur_kind_q)
			KIND_TYPE: begin
				item_value = frame_type_q;
				item_last  = (data_count_q == '0) && (pass_count_q == '0);
				next_kind  = (data_count_q != '0) ? KIND_DATA : KIND_PASS;
				next_idx   = '0;
			end
			KIND_DATA: begin
				item_value = data_store_q[cur_idx_q[DATA_AW-1:0]];
				item_last  = (idx_inc == data_cnt_ext) && (pass_count_q == '0);
				if (idx_inc < data_cnt_ext) begin
					next_kind = KIND_DATA;
					next_idx  = idx_inc;
				end
			end
			KIND_PASS: begin
				item_value = pass_store_q[cur_idx_q[PASS_AW-1:0]];
				item_last  = (idx_inc == pass_cnt_ext);
				next_kind  = KIND_PASS;
				next_idx   = idx_inc;
			end
			default: ;
		endcase
	end

	// Cursor: rewound by the closing stop byte, advanced on every load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_kind_q <= KIND_TYPE;
			cur_idx_q  <= '0;
		end else if (cmd.take_byte && in_frame_q && is_stop) begin
			cur_kind_q <= KIND_TYPE;
			cur_idx_q  <= '0;
		end else if (cmd.load_item) begin
			cur_kind_q <= next_kind;
			cur_idx_q  <= next_idx;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_item) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q     <= cur_kind_q;
			index_q    <= ENTRY_IDX_W'(cur_idx_q);
			value_q    <= item_value;
			overflow_q <= dropped_q;
			last_q     <= item_last;
		end
	end

	assign sts.stop_hit  = in_frame_q && is_stop;
	assign sts.out_free  = !valid_q || out_ready;
	assign sts.item_last = item_last;

	assign out_valid    = valid_q;
	assign out_kind     = kind_q;
	assign out_index    = index_q;
	assign out_value    = value_q;
	assign out_overflow = overflow_q;
	assign out_last     = last_q;

	// Fill counts never pass the store depths.
	a_data_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		data_count_q <= DATA_CW'(DATA_DEPTH))
		else $error("data count beyond store depth");

	a_pass_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_count_q <= PASS_CW'(PASS_DEPTH))
		else $error("password count beyond store depth");

	// A stalled beat is not overwritten by a new load.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !cmd.load_item)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[hw/rtl/delimited_command_frame_parser_unit.sv]
// Delimited command frame parser, top level.
// Channel rx takes one received byte per beat; channel entry gives one run
// entry per beat (kind, index, value, overflow flag, last mark). The cfg
// port writes start byte, stop byte and pass marker; the user must write
// them only while idle, which the block does not enforce. Bytes are taken
// one per cycle while no run is being sent. A closing stop byte starts a
// run of 1 + data count + password count entries (1 to 21); during the run
// rx is not ready. Once the stop beat is taken, the controller state register
// enters the run state and the first entry is then loaded into the output
// register; the rest follow one per cycle while the receiver does not stall,
// all walked through the single output register.
// The next byte is taken while the final entry still waits in the output
// register. A stall on entry holds the current beat and pauses the run.
// Reset restores the register defaults (2, 3, 35), closes any open frame
// and empties the output register; the stores need no clearing.
// Depends on dcfp_pkg, dcfp_rx_if, dcfp_entry_if, dcfp_ctrl, dcfp_datapath.
`default_nettype none

module delimited_command_frame_parser_unit import dcfp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dcfp_rx_if.sink                   rx,
	dcfp_entry_if.source              entry,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata
);

	dcfp_cmd_t cmd;
	dcfp_sts_t sts;
	logic      in_ready;

	// Sequencing of byte intake and run output.
	dcfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame state, stores and output register.
	dcfp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx_byte      (rx.rx_byte),
		.out_ready    (entry.ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (entry.valid),
		.out_kind     (entry.entry_kind),
		.out_index    (entry.entry_index),
		.out_value    (entry.entry_value),
		.out_overflow (entry.frame_overflow),
		.out_last     (entry.last_entry)
	);

	assign rx.ready = in_ready;

endmodule

`default_nettype wire
